@@ rtl/core/scp_pkg.sv @@
// ----------------------------------------------------------------------------
// Segment collision predictor package
// Widths, pipeline payload types and the shared scale-add-clamp helpers.
// ----------------------------------------------------------------------------
package scp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int HALF_W    = 31;
    localparam int NUM_W     = 34;                 // magnitude of the contact numerator
    localparam int DEN_W     = 33;                 // magnitude of the relative speed
    localparam int DVD_W     = NUM_W + FRAC_BITS;  // scaled numerator, one cell per bit
    localparam int CELLS     = DVD_W;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SHR_W     = PROD_W - FRAC_BITS;
    localparam int SUM_W     = SHR_W + 2;

    localparam logic signed [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] sc;
        logic [DATA_W-1:0]        sv_mag;
        logic                     sv_neg;
        logic [PROD_W-1:0]        step_prod;
        logic                     step_neg;
        logic                     overlap;
        logic                     possible;
        logic                     neg;
    } t_pay;

    typedef struct packed {
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem;
        logic [DVD_W-1:0] dvd;
        logic [DVD_W-1:0] quo;
        t_pay             pay;
    } t_div;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     sat;
    } t_clamp;

    // Center plus or minus a product magnitude scaled down by the fraction bits.
    function automatic logic signed [SUM_W-1:0] add_scaled(
        input logic signed [DATA_W-1:0] sc,
        input logic [PROD_W-1:0]        prod,
        input logic                     neg
    );
        logic signed [SUM_W-1:0] sc_ext;
        logic signed [SUM_W-1:0] m_ext;
        sc_ext = {{(SUM_W-DATA_W){sc[DATA_W-1]}}, sc};
        m_ext  = {{(SUM_W-SHR_W){1'b0}}, prod[PROD_W-1:FRAC_BITS]};
        return neg ? sc_ext - m_ext : sc_ext + m_ext;
    endfunction

    function automatic t_clamp clamp_sum(input logic signed [SUM_W-1:0] v);
        t_clamp r;
        r.sat   = 1'b0;
        r.value = v[DATA_W-1:0];
        if (v > SUM_W'(MAX_VAL)) begin
            r.sat   = 1'b1;
            r.value = MAX_VAL;
        end else if (v < SUM_W'(MIN_VAL)) begin
            r.sat   = 1'b1;
            r.value = MIN_VAL;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/scp_if.sv @@
// ----------------------------------------------------------------------------
// Segment collision predictor channels
// Valid/ready channels for segment pairs and for prediction results.
// ----------------------------------------------------------------------------
interface scp_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [scp_pkg::DATA_W-1:0]       self_center;
    logic        [scp_pkg::HALF_W-1:0]       self_half_length;
    logic signed [scp_pkg::DATA_W-1:0]       self_speed;
    logic signed [scp_pkg::DATA_W-1:0]       other_center;
    logic        [scp_pkg::HALF_W-1:0]       other_half_length;
    logic signed [scp_pkg::DATA_W-1:0]       other_speed;
    logic signed [scp_pkg::DATA_W-1:0]       step_time;

    modport source (output valid, self_center, self_half_length, self_speed,
                    other_center, other_half_length, other_speed, step_time,
                    input ready);
    modport sink   (input valid, self_center, self_half_length, self_speed,
                    other_center, other_half_length, other_speed, step_time,
                    output ready);
endinterface

interface scp_out_if;
    logic                              valid;
    logic                              ready;
    logic                              overlap_now;
    logic                              contact_possible;
    logic signed [scp_pkg::DATA_W-1:0] contact_time;
    logic signed [scp_pkg::DATA_W-1:0] contact_center;
    logic signed [scp_pkg::DATA_W-1:0] stepped_center;
    logic                              saturated;

    modport source (output valid, overlap_now, contact_possible, contact_time,
                    contact_center, stepped_center, saturated, input ready);
    modport sink   (input valid, overlap_now, contact_possible, contact_time,
                    contact_center, stepped_center, saturated, output ready);
endinterface

@@ rtl/core/segment_collision_predictor_core.sv @@
// ----------------------------------------------------------------------------
// Segment collision predictor core
// Predicts edge contact time and positions of two moving 1-D segments.
//
//   Channel  Dir  Carries
//   i_in     in   two segments (center, half-length, speed) and a time step
//   o_out    out  overlap, contact flag/time/center, stepped center, saturation
//
// One pair is taken per cycle while the output side does not stall; each result
// passes one front stage, one divider cell per quotient bit (50), and two
// back-end stages for the contact-center multiply and the output register.
// Each stage advances when it is empty or its successor advances, so bubbles
// are squeezed out and input transfers continue while a result waits, until
// every stage holds a pair.
// Reset is synchronous and clears only the valid bits of the stages.
// ----------------------------------------------------------------------------
module segment_collision_predictor_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    scp_in_if.sink    i_in,
    scp_out_if.source o_out
);
    import scp_pkg::*;

    logic w_valid [0:CELLS];
    t_div w_data  [0:CELLS];
    logic w_adv   [0:CELLS];
    logic w_take;

    scp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv[0]),
        .i_in    (i_in),
        .o_valid (w_valid[0]),
        .o_data  (w_data[0])
    );

    genvar k;
    generate
        for (k = 0; k < CELLS; k++) begin : g_cell
            scp_div_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv[k+1]),
                .i_valid (w_valid[k]),
                .i_data  (w_data[k]),
                .o_valid (w_valid[k+1]),
                .o_data  (w_data[k+1])
            );
            assign w_adv[k] = !w_valid[k] || w_adv[k+1];
        end
    endgenerate

    assign w_adv[CELLS] = !w_valid[CELLS] || w_take;

    scp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[CELLS]),
        .i_data  (w_data[CELLS]),
        .o_take  (w_take),
        .o_out   (o_out)
    );

    a_no_time_without_contact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.contact_possible |->
            o_out.contact_time == '0 && o_out.contact_center == '0)
        else $error("contact time or center set without a possible contact");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled while the result register is empty");

    a_reset_empties: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result valid right after reset");

    a_first_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> ##1 !o_out.valid)
        else $error("result appeared sooner than the pipeline depth allows");

endmodule

@@ rtl/core/scp_front.sv @@
// ----------------------------------------------------------------------------
// Segment collision predictor front stage
// Overlap test, contact numerator and speed magnitudes, step product.
// ----------------------------------------------------------------------------
module scp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    scp_in_if.sink              i_in,
    output logic                o_valid,
    output scp_pkg::t_div       o_data
);
    import scp_pkg::*;

    logic signed [DATA_W-1:0] sc, sv, oc, ov, dt;
    logic signed [DATA_W+1:0] sc34, oc34, sr34, or34;
    logic signed [DATA_W:0]   vrel, crel, vneg;
    logic signed [DATA_W+2:0] rsum35, crel35, num, numn;
    logic [DATA_W-1:0]        sv_mag, dt_mag;
    logic                     overlap;
    t_div                     n_data;
    logic                     r_valid;
    t_div                     r_data;

    assign sc = i_in.self_center;
    assign sv = i_in.self_speed;
    assign oc = i_in.other_center;
    assign ov = i_in.other_speed;
    assign dt = i_in.step_time;

    always_comb begin
        sc34 = {{2{sc[DATA_W-1]}}, sc};
        oc34 = {{2{oc[DATA_W-1]}}, oc};
        sr34 = {3'b000, i_in.self_half_length};
        or34 = {3'b000, i_in.other_half_length};
        if (sc == oc) begin
            overlap = 1'b1;
        end else if (sc < oc) begin
            overlap = (sc34 + sr34) >= (oc34 - or34);
        end else begin
            overlap = (sc34 - sr34) <= (oc34 + or34);
        end

        vrel   = {sv[DATA_W-1], sv} - {ov[DATA_W-1], ov};
        crel   = {sc[DATA_W-1], sc} - {oc[DATA_W-1], oc};
        vneg   = -vrel;
        rsum35 = {4'b0000, i_in.self_half_length} + {4'b0000, i_in.other_half_length};
        crel35 = {{2{crel[DATA_W]}}, crel};
        // Facing edges: self's right edge when self is at or left of other.
        num    = (sc <= oc) ? -(rsum35 + crel35) : (rsum35 - crel35);
        numn   = -num;
        sv_mag = sv[DATA_W-1] ? DATA_W'(-sv) : sv;
        dt_mag = dt[DATA_W-1] ? DATA_W'(-dt) : dt;

        n_data.den           = vrel[DATA_W] ? vneg[DEN_W-1:0] : vrel[DEN_W-1:0];
        n_data.rem           = '0;
        n_data.dvd           = {(num[DATA_W+2] ? numn[NUM_W-1:0] : num[NUM_W-1:0]),
                                {FRAC_BITS{1'b0}}};
        n_data.quo           = '0;
        n_data.pay.sc        = sc;
        n_data.pay.sv_mag    = sv_mag;
        n_data.pay.sv_neg    = sv[DATA_W-1];
        n_data.pay.step_prod = dt_mag * sv_mag;
        n_data.pay.step_neg  = dt[DATA_W-1] != sv[DATA_W-1];
        n_data.pay.overlap   = overlap;
        n_data.pay.possible  = sv != ov;
        n_data.pay.neg       = num[DATA_W+2] != vrel[DATA_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign i_in.ready = i_adv;
    assign o_valid    = r_valid;
    assign o_data     = r_data;

endmodule

@@ rtl/core/scp_div_cell.sv @@
// ----------------------------------------------------------------------------
// Segment collision predictor divider cell
// One restoring-division step: produces one quotient bit and hands on.
// ----------------------------------------------------------------------------
module scp_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_valid,
    input  scp_pkg::t_div i_data,
    output logic          o_valid,
    output scp_pkg::t_div o_data
);
    import scp_pkg::*;

    logic [DEN_W:0] trial, diff;
    logic           fits;
    t_div           n_data;
    logic           r_valid;
    t_div           r_data;

    always_comb begin
        trial      = {i_data.rem, i_data.dvd[DVD_W-1]};
        diff       = trial - {1'b0, i_data.den};
        fits       = trial >= {1'b0, i_data.den};
        n_data     = i_data;
        n_data.rem = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        n_data.dvd = {i_data.dvd[DVD_W-2:0], 1'b0};
        n_data.quo = {i_data.quo[DVD_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/core/scp_back.sv @@
// ----------------------------------------------------------------------------
// Segment collision predictor back end
// Clamps the contact time, forms both centers and holds the result register.
// ----------------------------------------------------------------------------
module scp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  scp_pkg::t_div i_data,
    output logic          o_take,
    scp_out_if.source     o_out
);
    import scp_pkg::*;

    logic                     en_b, en_c;
    logic [DVD_W-1:0]         q;
    logic                     big, sat_t, t_neg;
    logic [DATA_W-1:0]        tmag;
    logic signed [DATA_W-1:0] t_val;
    t_clamp                   step_c, cc_c;

    logic                     r_vb;
    logic signed [DATA_W-1:0] r_t;
    logic                     r_sat_t;
    logic [PROD_W-1:0]        r_cc_prod;
    logic                     r_cc_neg;
    logic signed [DATA_W-1:0] r_sc;
    logic                     r_possible;
    logic                     r_overlap;
    t_clamp                   r_step;

    logic                     r_vc;
    logic                     r_o_overlap, r_o_possible, r_o_sat;
    logic signed [DATA_W-1:0] r_o_t, r_o_cc, r_o_step;

    assign en_c   = !r_vc || o_out.ready;
    assign en_b   = !r_vb || en_c;
    assign o_take = en_b;

    always_comb begin
        q     = i_data.quo;
        big   = |q[DVD_W-1:DATA_W];
        sat_t = 1'b0;
        tmag  = q[DATA_W-1:0];
        if (i_data.pay.neg) begin
            if (big || (q[DATA_W-1] && (|q[DATA_W-2:0]))) begin
                sat_t = 1'b1;
                tmag  = MIN_VAL;
            end
        end else if (big || q[DATA_W-1]) begin
            sat_t = 1'b1;
            tmag  = MAX_VAL;
        end
        if (!i_data.pay.possible) begin
            sat_t = 1'b0;
            tmag  = '0;
        end
        t_neg  = i_data.pay.neg && (tmag != '0);
        t_val  = t_neg ? DATA_W'(-tmag) : tmag;
        step_c = clamp_sum(add_scaled(i_data.pay.sc, i_data.pay.step_prod,
                                      i_data.pay.step_neg));
        cc_c   = clamp_sum(add_scaled(r_sc, r_cc_prod, r_cc_neg));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (en_b) begin
                r_vb <= i_valid;
            end
            if (en_c) begin
                r_vc <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_t        <= t_val;
            r_sat_t    <= sat_t;
            r_cc_prod  <= i_data.pay.sv_mag * tmag;
            r_cc_neg   <= i_data.pay.sv_neg != t_neg;
            r_sc       <= i_data.pay.sc;
            r_possible <= i_data.pay.possible;
            r_overlap  <= i_data.pay.overlap;
            r_step     <= step_c;
        end
        if (en_c) begin
            r_o_overlap  <= r_overlap;
            r_o_possible <= r_possible;
            r_o_t        <= r_t;
            r_o_cc       <= r_possible ? cc_c.value : '0;
            r_o_step     <= r_step.value;
            r_o_sat      <= r_sat_t || r_step.sat || (r_possible && cc_c.sat);
        end
    end

    assign o_out.valid            = r_vc;
    assign o_out.overlap_now      = r_o_overlap;
    assign o_out.contact_possible = r_o_possible;
    assign o_out.contact_time     = r_o_t;
    assign o_out.contact_center   = r_o_cc;
    assign o_out.stepped_center   = r_o_step;
    assign o_out.saturated        = r_o_sat;

endmodule

@@ verif/tb_segment_collision_predictor_core.sv @@
// ----------------------------------------------------------------------------
// Segment collision predictor core testbench
// Drives segment pairs through the valid/ready channels, predicts overlap,
// contact time, contact center and stepped center in Q16.16, and checks each
// result transfer in order under random source and sink idling.
// ----------------------------------------------------------------------------
module tb_segment_collision_predictor_core;
    import scp_pkg::*;

    localparam int LATENCY   = 53;
    localparam int IDLE_LIMIT = 4000;
    localparam int N_RANDOM  = 1330;

    typedef struct packed {
        logic signed [31:0] sc;
        logic [30:0]        sr;
        logic signed [31:0] sv;
        logic signed [31:0] oc;
        logic [30:0]        orr;
        logic signed [31:0] ov;
        logic signed [31:0] dt;
    } t_pair;

    typedef struct packed {
        logic               overlap;
        logic               possible;
        logic signed [31:0] ctime;
        logic signed [31:0] ccenter;
        logic signed [31:0] stepped;
        logic               sat;
    } t_pred;

    logic i_clk;
    logic i_rst_n;
    scp_in_if  in_ch();
    scp_out_if out_ch();

    segment_collision_predictor_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    t_pair pending_pairs[$];
    t_pred expected_results[$];
    int    src_idle_pct;
    int    snk_idle_pct;
    int    errors;
    int    n_sent;
    int    n_checked;
    int    n_saturated;
    int    n_contact;
    int    idle_cycles;
    bit    stim_done;
    bit    in_taken;

    // Product magnitude truncated toward zero after the fraction shift.
    function automatic longint scaled_product(longint a, longint b);
        logic [63:0] m;
        logic        neg;
        neg = (a < 0) != (b < 0);
        m = (a < 0 ? -a : a) * (b < 0 ? -b : b);
        m = m >> FRAC_BITS;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp_word(longint v, ref logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic t_pred predict_contact(t_pair p);
        t_pred       r;
        longint      sc, sr, sv, oc, orr, ov, dt, vrel, num, t, cc, st;
        logic [63:0] q;
        logic        sat;
        sc = p.sc; sr = p.sr; sv = p.sv; oc = p.oc; orr = p.orr; ov = p.ov;
        dt = p.dt;
        sat = 1'b0;
        t = 0;
        cc = 0;
        if (sc == oc) r.overlap = 1'b1;
        else if (sc < oc) r.overlap = (sc + sr) >= (oc - orr);
        else r.overlap = (sc - sr) <= (oc + orr);
        r.possible = sv != ov;
        if (r.possible) begin
            vrel = sv - ov;
            num = (sc <= oc) ? -(sr + orr + sc - oc) : (sr + orr - (sc - oc));
            q = ((num < 0 ? -num : num) << FRAC_BITS) / (vrel < 0 ? -vrel : vrel);
            if ((num < 0) != (vrel < 0)) begin
                if (q > 64'h8000_0000) begin
                    sat = 1'b1;
                    t = -64'sd2147483648;
                end else t = -longint'(q);
            end else begin
                if (q > 64'h7FFF_FFFF) begin
                    sat = 1'b1;
                    t = 64'sd2147483647;
                end else t = longint'(q);
            end
            cc = clamp_word(sc + scaled_product(sv, t), sat);
        end
        st = clamp_word(sc + scaled_product(dt, sv), sat);
        r.stepped = 32'(st);
        r.ctime = 32'(t);
        r.ccenter = 32'(cc);
        r.sat = sat;
        return r;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 8) - 4;
            3: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic t_pair random_pair();
        t_pair p;
        p.sc  = pick_word();
        p.sr  = 31'(pick_word());
        p.sv  = pick_word();
        p.oc  = ($urandom_range(0, 3) == 0) ? p.sc : pick_word();
        p.orr = 31'(pick_word());
        p.ov  = ($urandom_range(0, 4) == 0) ? p.sv : pick_word();
        p.dt  = pick_word();
        return p;
    endfunction

    task automatic add_pair(input logic [31:0] sc, input logic [30:0] sr,
                            input logic [31:0] sv, input logic [31:0] oc,
                            input logic [30:0] orr, input logic [31:0] ov,
                            input logic [31:0] dt);
        pending_pairs.push_back('{sc, sr, sv, oc, orr, ov, dt});
    endtask

    // Driver: inputs change on the falling edge only. The head of the queue
    // is presented until the monitor sees its transfer and removes it.
    always @(negedge i_clk) begin
        t_pair p;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (!in_ch.valid || in_taken) begin
                in_taken = 1'b0;
                if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    p = pending_pairs[0];
                    in_ch.valid             <= 1'b1;
                    in_ch.self_center       <= p.sc;
                    in_ch.self_half_length  <= p.sr;
                    in_ch.self_speed        <= p.sv;
                    in_ch.other_center      <= p.oc;
                    in_ch.other_half_length <= p.orr;
                    in_ch.other_speed       <= p.ov;
                    in_ch.step_time         <= p.dt;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Monitor and predictor: sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                expected_results.push_back(predict_contact(t_pair'({in_ch.self_center,
                    in_ch.self_half_length, in_ch.self_speed, in_ch.other_center,
                    in_ch.other_half_length, in_ch.other_speed, in_ch.step_time})));
                void'(pending_pairs.pop_front());
                in_taken = 1'b1;
                n_sent++;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no prediction waiting");
                    errors++;
                end else begin
                    t_pred e;
                    e = expected_results.pop_front();
                    if (out_ch.overlap_now !== e.overlap) begin
                        $error("overlap_now exp %0d got %0d", e.overlap, out_ch.overlap_now);
                        errors++;
                    end
                    if (out_ch.contact_possible !== e.possible) begin
                        $error("contact_possible exp %0d got %0d", e.possible,
                               out_ch.contact_possible);
                        errors++;
                    end
                    if (out_ch.contact_time !== e.ctime) begin
                        $error("contact_time exp %0d got %0d", e.ctime, out_ch.contact_time);
                        errors++;
                    end
                    if (out_ch.contact_center !== e.ccenter) begin
                        $error("contact_center exp %0d got %0d", e.ccenter,
                               out_ch.contact_center);
                        errors++;
                    end
                    if (out_ch.stepped_center !== e.stepped) begin
                        $error("stepped_center exp %0d got %0d", e.stepped,
                               out_ch.stepped_center);
                        errors++;
                    end
                    if (out_ch.saturated !== e.sat) begin
                        $error("saturated exp %0d got %0d", e.sat, out_ch.saturated);
                        errors++;
                    end
                    n_checked++;
                    if (e.sat) n_saturated++;
                    if (e.possible) n_contact++;
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else if (!stim_done || expected_results.size() != 0)
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL segment_collision_predictor_core");
                $finish;
            end
        end
    end

    initial begin
        int phase;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.self_center = '0;
        in_ch.self_half_length = '0;
        in_ch.self_speed = '0;
        in_ch.other_center = '0;
        in_ch.other_half_length = '0;
        in_ch.other_speed = '0;
        in_ch.step_time = '0;
        out_ch.ready = 1'b0;
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_saturated = 0;
        n_contact = 0;
        idle_cycles = 0;
        stim_done = 1'b0;
        in_taken = 1'b0;
        src_idle_pct = 33;
        snk_idle_pct = 51;

        // Directed: equal centers, equal speeds, touching edges, extremes.
        add_pair(32'h0, 31'h0, 32'h0, 32'h0, 31'h0, 32'h0, 32'h0);
        add_pair(32'h0001_0000, 31'h0000_8000, 32'h0002_0000, 32'h0001_0000,
                 31'h0000_8000, 32'h0002_0000, 32'h0001_0000);
        add_pair(32'hFFFF_0000, 31'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                 31'h0001_0000, 32'hFFFF_0000, 32'h0002_0000);
        add_pair(32'h0005_0000, 31'h0001_0000, 32'hFFFF_0000, 32'h0000_0000,
                 31'h0001_0000, 32'h0001_0000, 32'h0000_8000);
        add_pair(32'h0000_0000, 31'h0001_0000, 32'h0000_0000, 32'h0002_0000,
                 31'h0001_0000, 32'h0000_0001, 32'hFFFF_0000);
        add_pair(32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        add_pair(32'h8000_0000, 31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        add_pair(32'h8000_0000, 31'h0, 32'h8000_0000, 32'h7FFF_FFFF, 31'h0,
                 32'h7FFF_FFFF, 32'h8000_0000);
        add_pair(32'h7FFF_FFFF, 31'h0, 32'h0000_0001, 32'h8000_0000, 31'h0,
                 32'h0000_0000, 32'h7FFF_FFFF);
        add_pair(32'h0000_0000, 31'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0001,
                 31'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        add_pair(32'h0000_0001, 31'h0, 32'hFFFF_FFFF, 32'h0000_0000, 31'h0,
                 32'h0000_0000, 32'h0000_0001);
        add_pair(32'h1234_5678, 31'h0000_0001, 32'h7FFF_FFFF, 32'h1234_5679,
                 31'h0, 32'h7FFF_FFFF, 32'h8000_0000);
        add_pair(32'hFFFF_FFFF, 31'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000,
                 31'h2AAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        add_pair(32'h5555_5555, 31'h2AAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                 31'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        for (int k = 0; k < N_RANDOM; k++) pending_pairs.push_back(random_pair());

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                src_idle_pct = 51;
                snk_idle_pct = 33;
            end else if (phase == 2) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            while (pending_pairs.size() > (2 - phase) * N_RANDOM / 3) @(posedge i_clk);
        end
        while (pending_pairs.size() != 0) @(posedge i_clk);
        stim_done = 1'b1;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("Checked %0d of %0d segment pairs: %0d with a defined contact time,",
                 n_checked, n_sent, n_contact);
        $display("%0d with a clamped result, under three source and sink idling mixes.",
                 n_saturated);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("PASS segment_collision_predictor_core");
        end else begin
            $display("FAIL segment_collision_predictor_core");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/scp_pkg.sv
rtl/core/scp_if.sv
rtl/core/scp_front.sv
rtl/core/scp_div_cell.sv
rtl/core/scp_back.sv
rtl/core/segment_collision_predictor_core.sv
verif/tb_segment_collision_predictor_core.sv
